@@ hdl/qte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// Types, widths and CORDIC constants for the quaternion to roll/pitch/yaw
// converter.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;

   // operand and vector widths
   localparam int OPW  = 34;              // atan2 operands, 1.0 = 2^28
   localparam int VECW = 38;              // CORDIC vector with growth headroom
   localparam int ZW   = 34;              // angle accumulator, 2^31 = pi
   localparam int T2W  = 30;              // saturated sine term
   localparam int SQW  = 57;              // square of the sine term
   localparam int RADW = 58;              // isqrt working width
   localparam int SQRT_STEPS = 29;        // one result bit per step

   localparam logic signed [OPW-1:0] ONE_Q28  = OPW'(64'sd268435456);
   localparam logic signed [OPW-1:0] MONE_Q28 = -ONE_Q28;
   localparam logic signed [ZW-1:0]  HALF_PI  = ZW'(64'sd1073741824);
   localparam logic signed [ZW-1:0]  ROUND_HALF = ZW'(64'sd32768);
   localparam logic signed [17:0]    PITCH_MAX = 18'sd16384;
   localparam logic signed [17:0]    PITCH_MIN = -18'sd16384;

   localparam logic signed [ZW-1:0] ATAN_BAM [ATAN_ENTRIES] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10680350,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81
   };

   typedef struct packed {
      logic signed [VECW-1:0] x;
      logic signed [VECW-1:0] y;
      logic signed [ZW-1:0]   z;
      logic                   zero;
   } cvec_type;

   typedef struct packed {
      logic [RADW-1:0]        op;
      logic [RADW-1:0]        res;
      logic signed [OPW-1:0]  t0;
      logic signed [OPW-1:0]  t1;
      logic signed [OPW-1:0]  t3;
      logic signed [OPW-1:0]  t4;
      logic signed [T2W-1:0]  t2;
      logic                   clamped;
   } sqrt_type;

   typedef struct packed {
      cvec_type roll;
      cvec_type pitch;
      cvec_type yaw;
      logic     pole;
      logic     pneg;
      logic     clamped;
   } lanes_type;

   // quadrant fold ahead of the rotations
   function automatic cvec_type cordic_fold(logic signed [OPW-1:0] y,
                                            logic signed [OPW-1:0] x);
      cvec_type v;
      logic signed [VECW-1:0] xe;
      logic signed [VECW-1:0] ye;
      xe = VECW'(x);
      ye = VECW'(y);
      v.zero = (x == '0) && (y == '0);
      if (x < 0) begin
         if (y >= 0) begin
            v.x = ye;
            v.y = -xe;
            v.z = HALF_PI;
         end else begin
            v.x = -ye;
            v.y = xe;
            v.z = -HALF_PI;
         end
      end else begin
         v.x = xe;
         v.y = ye;
         v.z = '0;
      end
      return v;
   endfunction

   // one vectoring micro-rotation; i is a constant at every call site
   function automatic cvec_type cordic_rot(cvec_type v, int i);
      cvec_type r;
      logic signed [VECW-1:0] xs;
      logic signed [VECW-1:0] ys;
      xs = v.x >>> i;
      ys = v.y >>> i;
      r.zero = v.zero;
      if (v.y > 0) begin
         r.x = v.x + ys;
         r.y = v.y - xs;
         r.z = v.z + ATAN_BAM[i];
      end else begin
         r.x = v.x - ys;
         r.y = v.y + xs;
         r.z = v.z - ATAN_BAM[i];
      end
      return r;
   endfunction

   // round half up to 16 fraction bits below the 2^31 = pi scale
   function automatic logic signed [17:0] bam_round(logic signed [ZW-1:0] z);
      logic signed [ZW-1:0] s;
      s = (z + ROUND_HALF) >>> 16;
      return s[17:0];
   endfunction

endpackage
`default_nettype wire

@@ hdl/quaternion_to_euler_rpy.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_rpy
// Quaternion (Q2.14) to Z-Y-X Euler angles in 16-bit binary angle units.
//
// Input channel req_*: one quaternion per transaction (x, y, z, w).
// Result channel rsp_*: roll, pitch, yaw (32768 = pi) and pitch_clamped,
// set when the pitch sine term was saturated to +-1.
// The pipeline runs from acceptance to rsp_valid through products, sums and
// saturation, square, a 29-step integer square root (one bit per stage),
// the quadrant fold, CORDIC_STAGES rotation stages and the output register.
// Throughput is one transaction per cycle while rsp_ is not stalled; the three
// atan2 lanes run side by side through the same stages.
// A stall on rsp_ while rsp_valid is high freezes the whole pipeline in place and is passed back
// on req_stall in the same cycle; nothing is lost or repeated.
// Reset clears the stage valid bits only; the pipeline is empty after it.
// ----------------------------------------------------------------------------
module quaternion_to_euler_rpy (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   input  wire logic signed [15:0] req_quat_w,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_roll,
   output logic signed [15:0]      rsp_pitch,
   output logic signed [15:0]      rsp_yaw,
   output logic                    rsp_pitch_clamped
);
   import qte_pkg::*;

   logic en;

   // products
   logic signed [OPW-1:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_wz_ff;
   logic signed [OPW-1:0] p_xy_ff, p_zz_ff, p_wy_ff, p_zx_ff;
   logic                  va_ff;

   // operands
   logic signed [OPW-1:0] t0_ff, t1_ff, t3_ff, t4_ff;
   logic signed [OPW-1:0] t2_raw;
   logic signed [T2W-1:0] t2_ff, t2_in;
   logic                  clamp_ff, clamp_in;
   logic                  vb_ff;

   // square of the sine term
   logic [SQW-1:0]        sq_ff;
   logic signed [2*T2W-1:0] sq_full;
   logic signed [OPW-1:0] t0c_ff, t1c_ff, t3c_ff, t4c_ff;
   logic signed [T2W-1:0] t2c_ff;
   logic                  clampc_ff;
   logic                  vc_ff;

   sqrt_type  sq_in  [SQRT_STEPS];
   sqrt_type  sqs_ff [SQRT_STEPS];
   logic      sqv_ff [SQRT_STEPS];

   lanes_type cd_in  [CORDIC_STAGES+1];
   lanes_type cd_ff  [CORDIC_STAGES+1];
   logic      cdv_ff [CORDIC_STAGES+1];

   logic signed [17:0] roll_r, pitch_r, yaw_r;
   logic signed [15:0] pitch_in;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (en) begin
         p_wx_ff <= OPW'(req_quat_w * req_quat_x);
         p_yz_ff <= OPW'(req_quat_y * req_quat_z);
         p_xx_ff <= OPW'(req_quat_x * req_quat_x);
         p_yy_ff <= OPW'(req_quat_y * req_quat_y);
         p_wz_ff <= OPW'(req_quat_w * req_quat_z);
         p_xy_ff <= OPW'(req_quat_x * req_quat_y);
         p_zz_ff <= OPW'(req_quat_z * req_quat_z);
         p_wy_ff <= OPW'(req_quat_w * req_quat_y);
         p_zx_ff <= OPW'(req_quat_z * req_quat_x);
      end
   end

   always_comb begin
      t2_raw   = (p_wy_ff - p_zx_ff) <<< 1;
      priority if (t2_raw > ONE_Q28) begin
         t2_in    = ONE_Q28[T2W-1:0];
         clamp_in = 1'b1;
      end else if (t2_raw < MONE_Q28) begin
         t2_in    = MONE_Q28[T2W-1:0];
         clamp_in = 1'b1;
      end else begin
         t2_in    = t2_raw[T2W-1:0];
         clamp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff    <= (p_wx_ff + p_yz_ff) <<< 1;
         t1_ff    <= ONE_Q28 - ((p_xx_ff + p_yy_ff) <<< 1);
         t3_ff    <= (p_wz_ff + p_xy_ff) <<< 1;
         t4_ff    <= ONE_Q28 - ((p_yy_ff + p_zz_ff) <<< 1);
         t2_ff    <= t2_in;
         clamp_ff <= clamp_in;
      end
   end

   assign sq_full = t2_ff * t2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff     <= sq_full[SQW-1:0];
         t0c_ff    <= t0_ff;
         t1c_ff    <= t1_ff;
         t3c_ff    <= t3_ff;
         t4c_ff    <= t4_ff;
         t2c_ff    <= t2_ff;
         clampc_ff <= clamp_ff;
      end
   end

   // integer square root of 2^56 - t2^2, one result bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [RADW-1:0] BIT = RADW'(1) << (2*(SQRT_STEPS-1) - 2*k);
      sqrt_type prev;
      logic [RADW-1:0] sum;

      always_comb begin
         if (k == 0) begin
            prev.op      = (RADW'(1) << (2*(SQRT_STEPS-1))) - RADW'(sq_ff);
            prev.res     = '0;
            prev.t0      = t0c_ff;
            prev.t1      = t1c_ff;
            prev.t3      = t3c_ff;
            prev.t4      = t4c_ff;
            prev.t2      = t2c_ff;
            prev.clamped = clampc_ff;
         end else begin
            prev = sqs_ff[(k == 0) ? 0 : k-1];
         end
         sum       = prev.res + BIT;
         sq_in[k]  = prev;
         if (prev.op >= sum) begin
            sq_in[k].op  = prev.op - sum;
            sq_in[k].res = (prev.res >> 1) + BIT;
         end else begin
            sq_in[k].res = prev.res >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sqs_ff[k] <= sq_in[k];
         end
      end
   end

   // fold and CORDIC rotations, three lanes abreast
   always_comb begin
      logic signed [OPW-1:0] c;
      c = OPW'(sqs_ff[SQRT_STEPS-1].res[T2W-2:0]);
      cd_in[0].roll    = cordic_fold(sqs_ff[SQRT_STEPS-1].t0, sqs_ff[SQRT_STEPS-1].t1);
      cd_in[0].yaw     = cordic_fold(sqs_ff[SQRT_STEPS-1].t3, sqs_ff[SQRT_STEPS-1].t4);
      cd_in[0].pitch   = cordic_fold(OPW'(sqs_ff[SQRT_STEPS-1].t2), c);
      cd_in[0].pole    = (c == '0);
      cd_in[0].pneg    = sqs_ff[SQRT_STEPS-1].t2[T2W-1];
      cd_in[0].clamped = sqs_ff[SQRT_STEPS-1].clamped;
   end

   for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_cordic
      always_comb begin
         cd_in[i]       = cd_ff[i-1];
         cd_in[i].roll  = cordic_rot(cd_ff[i-1].roll, i-1);
         cd_in[i].pitch = cordic_rot(cd_ff[i-1].pitch, i-1);
         cd_in[i].yaw   = cordic_rot(cd_ff[i-1].yaw, i-1);
      end
   end

   for (genvar i = 0; i <= CORDIC_STAGES; i++) begin : g_cd_reg
      always_ff @(posedge clock) begin
         if (en) begin
            cd_ff[i] <= cd_in[i];
         end
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            sqv_ff[k] <= 1'b0;
         end
         for (int i = 0; i <= CORDIC_STAGES; i++) begin
            cdv_ff[i] <= 1'b0;
         end
         rsp_valid <= 1'b0;
      end else if (en) begin
         va_ff     <= req_valid;
         vb_ff     <= va_ff;
         vc_ff     <= vb_ff;
         sqv_ff[0] <= vc_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            sqv_ff[k] <= sqv_ff[k-1];
         end
         cdv_ff[0] <= sqv_ff[SQRT_STEPS-1];
         for (int i = 1; i <= CORDIC_STAGES; i++) begin
            cdv_ff[i] <= cdv_ff[i-1];
         end
         rsp_valid <= cdv_ff[CORDIC_STAGES];
      end
   end

   // rounding, zero vector and pole handling
   always_comb begin
      roll_r  = bam_round(cd_ff[CORDIC_STAGES].roll.z);
      pitch_r = bam_round(cd_ff[CORDIC_STAGES].pitch.z);
      yaw_r   = bam_round(cd_ff[CORDIC_STAGES].yaw.z);
      priority if (cd_ff[CORDIC_STAGES].pole) begin
         pitch_in = cd_ff[CORDIC_STAGES].pneg ? PITCH_MIN[15:0] : PITCH_MAX[15:0];
      end else if (pitch_r > PITCH_MAX) begin
         pitch_in = PITCH_MAX[15:0];
      end else if (pitch_r < PITCH_MIN) begin
         pitch_in = PITCH_MIN[15:0];
      end else begin
         pitch_in = pitch_r[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_roll          <= cd_ff[CORDIC_STAGES].roll.zero ? '0 : roll_r[15:0];
         rsp_yaw           <= cd_ff[CORDIC_STAGES].yaw.zero ? '0 : yaw_r[15:0];
         rsp_pitch         <= pitch_in;
         rsp_pitch_clamped <= cd_ff[CORDIC_STAGES].clamped;
      end
   end

endmodule
`default_nettype wire
